>>> src/three_band_biquad_tone_control_assert.svh
// Assertion macros shared by the tone control modules.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef THREE_BAND_BIQUAD_TONE_CONTROL_ASSERT_SVH
`define THREE_BAND_BIQUAD_TONE_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define TBTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tone control assertion failed");

// Consequent must hold in the cycle after the antecedent
`define TBTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tone control assertion failed");

`else

`define TBTC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TBTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/tbtc_pkg.sv
package tbtc_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int GAIN_W      = 14;
	localparam int COEF_WORD_W = 64;
	localparam int FB_W        = 48;
	localparam int ACC_W       = 32;
	localparam int OPB_W       = 17;
	localparam int REG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// Fixed-point scaling
	localparam int COEF_SHIFT = 14;
	localparam int GAIN_SHIFT = 12;

	// Gain range and reset
	localparam logic [GAIN_W-1:0] GAIN_MIN   = 14'd5;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = 14'd8192;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd2048;

	// Coefficient reset words
	localparam logic [COEF_WORD_W-1:0] LOW_COEF_RESET  = 64'd9479232816455352326;
	localparam logic [COEF_WORD_W-1:0] MID_COEF_RESET  = 64'd10394580863667931078;
	localparam logic [COEF_WORD_W-1:0] HIGH_COEF_RESET = 64'd11247796404724577084;
	localparam logic [FB_W-1:0]        FB_RESET        = 48'd45128034172042;

	// Sequencing: three filter bands, then a gain phase
	localparam int NUM_BANDS = 3;
	localparam int BAND_W    = 2;
	localparam int TAP_W     = 3;
	localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
	localparam logic [BAND_W-1:0] BAND_GAIN = 2'd3;
	localparam logic [TAP_W-1:0]  TAP_FIRST     = 3'd0;
	localparam logic [TAP_W-1:0]  TAP_A1        = 3'd3;
	localparam logic [TAP_W-1:0]  TAP_LAST      = 3'd4;
	localparam logic [TAP_W-1:0]  GAIN_TAP_LAST = 3'd2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOW_GAIN    = 3'd0,
		REG_MID_GAIN    = 3'd1,
		REG_HIGH_GAIN   = 3'd2,
		REG_LOW_COEFFS  = 3'd3,
		REG_MID_COEFFS  = 3'd4,
		REG_HIGH_COEFFS = 3'd5,
		REG_FB_COEFFS   = 3'd6
	} tbtc_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} tbtc_state_t;

	// Controller to datapath
	typedef struct packed {
		logic              load;
		logic              mul_en;
		logic [BAND_W-1:0] band;
		logic [TAP_W-1:0]  tap;
		logic              finish;
	} tbtc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} tbtc_status_t;

endpackage

>>> src/tbtc_in_if.sv
interface tbtc_in_if;
	import tbtc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

>>> src/tbtc_out_if.sv
interface tbtc_out_if;
	import tbtc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

>>> src/tbtc_cfg_if.sv
interface tbtc_cfg_if;
	import tbtc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> src/three_band_biquad_tone_control.sv
// Three-band tone control: low, band and high biquad filters, weighted and summed.
// Channels: din takes one signed 16-bit sample per beat (valid/ready), dout returns
// one signed 16-bit sample per input beat, cfg writes one register per beat by index
// (0..2 gains, 3..5 filter coefficient words, 6 second feedback coefficients).
// cfg is always ready; write it only while no sample is in flight.
// Each sample takes 18 products through one shared 16x17 multiplier and a 32-bit
// accumulator, one product a cycle, then a drain state for the accumulator and a
// finish state that loads the output register. din is ready again from the edge
// that loads the output register, so the next sample is taken only after the
// previous one has finished.
// The output register holds a finished result while dout stalls; the next sample
// is still accepted and runs, then waits before its final load until the held
// result is taken.
// Reset (arst_n low) clears the filter histories, restores gains and coefficients
// to their defaults and empties the output register.
module three_band_biquad_tone_control (
	input logic        clk,
	input logic        arst_n,
	tbtc_in_if.sink    din,
	tbtc_out_if.source dout,
	tbtc_cfg_if.sink   cfg
);
	import tbtc_pkg::*;

	tbtc_cmd_t    cmd;
	tbtc_status_t stat;
	logic         in_ready;

	assign din.ready = in_ready;
	assign cfg.ready = 1'b1;

	// Sequencer
	tbtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Multiply-accumulate datapath and registers
	tbtc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample_in  (din.sample_in),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.sample_out (dout.sample_out)
	);

endmodule

>>> src/tbtc_ctrl.sv
`include "three_band_biquad_tone_control_assert.svh"

module tbtc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tbtc_pkg::tbtc_status_t stat,
	output tbtc_pkg::tbtc_cmd_t    cmd
);
	import tbtc_pkg::*;

	tbtc_state_t       state_q, state_d;
	logic [BAND_W-1:0] band_q;
	logic [TAP_W-1:0]  tap_q;
	logic              last_tap;
	logic              run_done;
	logic              accept;

	// Last product of the current band or of the gain phase
	assign last_tap = (band_q == BAND_GAIN) ? (tap_q == GAIN_TAP_LAST) : (tap_q == TAP_LAST);
	assign run_done = (band_q == BAND_GAIN) && last_tap;
	assign accept   = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_RUN;
			ST_RUN:   if (run_done) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.mul_en = 1'b0;
		cmd.band   = band_q;
		cmd.tap    = tap_q;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN:   cmd.mul_en = 1'b1;
			ST_DRAIN: ;
			ST_FIN:   cmd.finish = stat.out_free;
			default:  ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the band and tap counters through the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= BAND_LOW;
			tap_q  <= TAP_FIRST;
		end else if (state_q == ST_RUN) begin
			if (last_tap) begin
				tap_q  <= TAP_FIRST;
				band_q <= band_q + 2'd1;
			end else begin
				tap_q <= tap_q + 3'd1;
			end
		end else begin
			band_q <= BAND_LOW;
			tap_q  <= TAP_FIRST;
		end
	end

	`TBTC_ASSERT_NEXT(a_accept_starts_run, clk, arst_n, accept,
		state_q == ST_RUN && band_q == BAND_LOW && tap_q == TAP_FIRST)
	`TBTC_ASSERT_NEXT(a_finish_to_idle, clk, arst_n, cmd.finish, state_q == ST_IDLE)
	`TBTC_ASSERT_SAME(a_tap_bound, clk, arst_n, band_q != BAND_GAIN, tap_q <= TAP_LAST)

endmodule

>>> src/tbtc_dp.sv
`include "three_band_biquad_tone_control_assert.svh"

module tbtc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tbtc_pkg::tbtc_cmd_t              cmd,
	output tbtc_pkg::tbtc_status_t           stat,
	input  logic signed [tbtc_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                             cfg_we,
	input  logic [tbtc_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [tbtc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [tbtc_pkg::SAMPLE_W-1:0] sample_out
);
	import tbtc_pkg::*;

	// Configuration
	logic [GAIN_W-1:0]      gain_q [NUM_BANDS];
	logic [COEF_WORD_W-1:0] coef_q [NUM_BANDS];
	logic [FB_W-1:0]        fb_q;

	// Filter state
	logic signed [SAMPLE_W-1:0] x0_q, x1_q, x2_q;
	logic signed [SAMPLE_W-1:0] yh0_q [NUM_BANDS];
	logic signed [SAMPLE_W-1:0] yh1_q [NUM_BANDS];

	// Multiplier operands and product stage
	logic signed [COEF_W-1:0]        op_a;
	logic signed [OPB_W-1:0]         op_b;
	logic signed [COEF_W+OPB_W-1:0]  prod;
	logic [ACC_W-1:0]                prod_s1;
	logic [BAND_W-1:0]               band_s1;
	logic [TAP_W-1:0]                tap_s1;
	logic                            valid_s1;

	// Accumulator
	logic [ACC_W-1:0]       acc_q;
	logic [ACC_W-1:0]       term;
	logic [ACC_W-1:0]       acc_d;
	logic                   gain_ok;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                   out_valid_q;
	logic [GAIN_W-1:0]      cfg_gain;

	assign cfg_gain = cfg_data[GAIN_W-1:0];
	assign gain_ok  = (cfg_gain >= GAIN_MIN) && (cfg_gain <= GAIN_MAX);

	// Register writes; out-of-range gains and unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0] <= GAIN_RESET;
			gain_q[1] <= GAIN_RESET;
			gain_q[2] <= GAIN_RESET;
			coef_q[0] <= LOW_COEF_RESET;
			coef_q[1] <= MID_COEF_RESET;
			coef_q[2] <= HIGH_COEF_RESET;
			fb_q      <= FB_RESET;
		end else if (cfg_we) begin
			unique case (tbtc_reg_t'(cfg_index))
				REG_LOW_GAIN:    if (gain_ok) gain_q[0] <= cfg_gain;
				REG_MID_GAIN:    if (gain_ok) gain_q[1] <= cfg_gain;
				REG_HIGH_GAIN:   if (gain_ok) gain_q[2] <= cfg_gain;
				REG_LOW_COEFFS:  coef_q[0] <= cfg_data;
				REG_MID_COEFFS:  coef_q[1] <= cfg_data;
				REG_HIGH_COEFFS: coef_q[2] <= cfg_data;
				REG_FB_COEFFS:   fb_q <= cfg_data[FB_W-1:0];
				default:         ;
			endcase
		end
	end

	// Select operands: coefficient times history, or band output times gain
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (cmd.band == BAND_GAIN) begin
			op_a = yh0_q[cmd.tap[BAND_W-1:0]];
			op_b = $signed({{(OPB_W-GAIN_W){1'b0}}, gain_q[cmd.tap[BAND_W-1:0]]});
		end else begin
			unique case (cmd.tap)
				3'd0: begin
					op_a = $signed(coef_q[cmd.band][0 +: COEF_W]);
					op_b = {x0_q[SAMPLE_W-1], x0_q};
				end
				3'd1: begin
					op_a = $signed(coef_q[cmd.band][COEF_W +: COEF_W]);
					op_b = {x1_q[SAMPLE_W-1], x1_q};
				end
				3'd2: begin
					op_a = $signed(coef_q[cmd.band][2*COEF_W +: COEF_W]);
					op_b = {x2_q[SAMPLE_W-1], x2_q};
				end
				3'd3: begin
					op_a = $signed(coef_q[cmd.band][3*COEF_W +: COEF_W]);
					op_b = {yh0_q[cmd.band][SAMPLE_W-1], yh0_q[cmd.band]};
				end
				3'd4: begin
					op_a = $signed(fb_q[COEF_W*cmd.band +: COEF_W]);
					op_b = {yh1_q[cmd.band][SAMPLE_W-1], yh1_q[cmd.band]};
				end
				default: ;
			endcase
		end
	end

	assign prod = op_a * op_b;

	// Product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod[ACC_W-1:0];
		band_s1 <= cmd.band;
		tap_s1  <= cmd.tap;
	end

	// Feedback terms subtract; first term of a band or of the gain phase restarts
	assign term  = ((band_s1 != BAND_GAIN) && (tap_s1 >= TAP_A1)) ? (32'd0 - prod_s1) : prod_s1;
	assign acc_d = (tap_s1 == TAP_FIRST) ? term : acc_q + term;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= acc_d;
		end
	end

	// Capture the sample; shift input history when the result is loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (cmd.finish) begin
			x1_q <= x0_q;
			x2_q <= x1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= sample_in;
		end
	end

	// Push each band's new output into its history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANDS; i++) begin
				yh0_q[i] <= '0;
				yh1_q[i] <= '0;
			end
		end else if (valid_s1 && (band_s1 != BAND_GAIN) && (tap_s1 == TAP_LAST)) begin
			yh1_q[band_s1] <= yh0_q[band_s1];
			yh0_q[band_s1] <= $signed(acc_d[COEF_SHIFT +: SAMPLE_W]);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= $signed(acc_q[GAIN_SHIFT +: SAMPLE_W]);
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign sample_out    = out_q;

	`TBTC_ASSERT_SAME(a_finish_drained, clk, arst_n, cmd.finish, !valid_s1 && stat.out_free)
	`TBTC_ASSERT_NEXT(a_finish_fills_out, clk, arst_n, cmd.finish, out_valid_q)
	`TBTC_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid_q && !out_ready,
		out_valid_q && $stable(out_q))

endmodule

>>> verif/tb_three_band_biquad_tone_control.sv
`timescale 1ns / 100ps

module tb_three_band_biquad_tone_control;
	import tbtc_pkg::*;

	localparam int RUN_LIMIT     = 400000;
	localparam int IDLE_SETTLE   = 25;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 108;
	// Index 7 maps to no register
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Tone control predictor plus the queue of samples still owed by the block
	class tone_scoreboard;
		logic [GAIN_W-1:0]      band_gain [NUM_BANDS];
		logic [COEF_WORD_W-1:0] band_coef [NUM_BANDS];
		logic [FB_W-1:0]        fb_coef;
		shortint                x_hist [2];
		shortint                y_hist [NUM_BANDS][2];
		shortint                owed_q [$];
		int                     n_checked;
		int                     n_errors;

		function new();
			band_gain[0] = GAIN_RESET;
			band_gain[1] = GAIN_RESET;
			band_gain[2] = GAIN_RESET;
			band_coef[0] = LOW_COEF_RESET;
			band_coef[1] = MID_COEF_RESET;
			band_coef[2] = HIGH_COEF_RESET;
			fb_coef = FB_RESET;
			x_hist = '{0, 0};
			for (int b = 0; b < NUM_BANDS; b++) y_hist[b] = '{0, 0};
			n_checked = 0;
			n_errors = 0;
		endfunction

		// Apply a register write the way the block does
		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			logic [GAIN_W-1:0] g;
			g = data[GAIN_W-1:0];
			case (idx)
				REG_LOW_GAIN, REG_MID_GAIN, REG_HIGH_GAIN: begin
					if (g >= GAIN_MIN && g <= GAIN_MAX) band_gain[idx] = g;
				end
				REG_LOW_COEFFS, REG_MID_COEFFS, REG_HIGH_COEFFS: begin
					band_coef[int'(idx) - int'(REG_LOW_COEFFS)] = data;
				end
				REG_FB_COEFFS: fb_coef = data[FB_W-1:0];
				default: ;
			endcase
		endfunction

		// One direct form I biquad step; the accumulator wraps at 32 bits
		function shortint run_band(int b, shortint x0);
			logic signed [COEF_W-1:0] c0, c1, c2, a1, a2;
			int      acc;
			shortint y;
			c0 = band_coef[b][15:0];
			c1 = band_coef[b][31:16];
			c2 = band_coef[b][47:32];
			a1 = band_coef[b][63:48];
			a2 = fb_coef[16*b +: 16];
			acc = int'(c0) * int'(x0) + int'(c1) * int'(x_hist[0])
				+ int'(c2) * int'(x_hist[1])
				- int'(a1) * int'(y_hist[b][0]) - int'(a2) * int'(y_hist[b][1]);
			y = shortint'(acc >>> COEF_SHIFT);
			y_hist[b][1] = y_hist[b][0];
			y_hist[b][0] = y;
			return y;
		endfunction

		// Filter an accepted sample and queue the mixed output
		function void note_sample(shortint x);
			shortint yb [NUM_BANDS];
			int      mix;
			mix = 0;
			for (int b = 0; b < NUM_BANDS; b++) begin
				yb[b] = run_band(b, x);
				mix += int'(yb[b]) * int'(band_gain[b]);
			end
			x_hist[1] = x_hist[0];
			x_hist[0] = x;
			owed_q.push_back(shortint'(mix >>> GAIN_SHIFT));
		endfunction

		function void check_result(shortint got);
			shortint want;
			n_checked++;
			if (owed_q.size() == 0) begin
				$error("sample_out: unexpected beat, expected none, actual %0d", got);
				n_errors++;
			end else begin
				want = owed_q.pop_front();
				if (want != got) begin
					$error("sample_out: expected %0d, actual %0d", want, got);
					n_errors++;
				end
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   cycle_count = 0;
	int   n_sent = 0;
	int   n_writes = 0;
	int   n_settings = 0;
	tone_scoreboard sb;

	tbtc_in_if  din_if();
	tbtc_out_if dout_if();
	tbtc_cfg_if cfg_if();

	three_band_biquad_tone_control dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Check every output beat
	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) sb.check_result(dout_if.sample_out);
	end

	// Stall the output side a random number of cycles before each beat (no stall while calm)
	initial begin
		int stall;
		dout_if.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!dout_if.valid);
		end
	end

	// Offer one sample, hold it until taken, then idle a random gap (no gap while calm)
	task automatic send_sample(input shortint x);
		int gap;
		din_if.valid <= 1'b1;
		din_if.sample_in <= x;
		do @(posedge clk); while (!din_if.ready);
		sb.note_sample(x);
		n_sent++;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
		n_writes++;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and hold off until every owed sample has come back
	task automatic wait_idle();
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
		n_settings++;
	endtask

	function automatic shortint pick_sample();
		case ($urandom_range(0, 7))
			0: return shortint'(16'h7FFF);
			1: return shortint'(16'h8000);
			2: return shortint'($urandom_range(0, 64) - 32);
			default: return shortint'($urandom);
		endcase
	endfunction

	// Gain words: edges, out-of-range values, junk above the gain field
	function automatic logic [CFG_DATA_W-1:0] pick_gain_word();
		logic [CFG_DATA_W-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: w[GAIN_W-1:0] = GAIN_MIN;
			1: w[GAIN_W-1:0] = GAIN_MAX;
			2: w[GAIN_W-1:0] = 14'($urandom_range(0, 4));
			3: w[GAIN_W-1:0] = 14'($urandom_range(8193, 16383));
			default: w[GAIN_W-1:0] = 14'($urandom_range(5, 8192));
		endcase
		if ($urandom_range(0, 1)) w[CFG_DATA_W-1:GAIN_W] = '0;
		return w;
	endfunction

	// Coefficient words: mostly near the defaults so the filters stay sane
	function automatic logic [CFG_DATA_W-1:0] pick_coef_word(input logic [CFG_DATA_W-1:0] base);
		logic [CFG_DATA_W-1:0] w;
		w = base;
		case ($urandom_range(0, 5))
			0: w = {$urandom, $urandom};
			1: begin
				for (int k = 0; k < 4; k++) begin
					case ($urandom_range(0, 3))
						0: w[16*k +: 16] = 16'h7FFF;
						1: w[16*k +: 16] = 16'h8000;
						2: w[16*k +: 16] = 16'h0000;
						default: w[16*k +: 16] = 16'($urandom);
					endcase
				end
			end
			2, 3: w = base ^ {4{16'($urandom_range(0, 255))}};
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		logic [REG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] word;
		sb = new();
		arst_n = 1'b0;
		calm = 1'b0;
		din_if.valid <= 1'b0;
		din_if.sample_in <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: full-scale steps and alternating patterns
		send_sample(16'sd0);
		send_sample(shortint'(16'h7FFF));
		send_sample(shortint'(16'h7FFF));
		send_sample(shortint'(16'h7FFF));
		send_sample(shortint'(16'h8000));
		send_sample(shortint'(16'h8000));
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(shortint'(16'h5555));
		send_sample(shortint'(16'hAAAA));
		send_sample(16'sd0);
		wait_idle();

		// Rejected gains, gain edges, unknown index, extreme coefficients
		write_reg(REG_LOW_GAIN, 64'd4);
		write_reg(REG_MID_GAIN, 64'd8193);
		write_reg(REG_HIGH_GAIN, 64'd0);
		write_reg(REG_HIGH_GAIN, 64'd16383);
		write_reg(REG_LOW_GAIN, 64'hFFFF_FFFF_FFFF_C005);
		write_reg(REG_MID_GAIN, 64'd8192);
		write_reg(REG_HIGH_GAIN, 64'd8192);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_LOW_COEFFS, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(REG_MID_COEFFS, 64'h8000_8000_8000_8000);
		write_reg(REG_HIGH_COEFFS, 64'h8000_7FFF_8000_7FFF);
		write_reg(REG_FB_COEFFS, 64'hFFFF_7FFF_8000_7FFF);
		send_sample(shortint'(16'h7FFF));
		send_sample(shortint'(16'h8000));
		send_sample(shortint'(16'h7FFF));
		send_sample(shortint'(16'h8000));
		send_sample(16'sd12345);
		send_sample(16'sd0);
		wait_idle();

		// Coefficients and low gain back to defaults before the random phases
		write_reg(REG_LOW_COEFFS, LOW_COEF_RESET);
		write_reg(REG_MID_COEFFS, MID_COEF_RESET);
		write_reg(REG_HIGH_COEFFS, HIGH_COEF_RESET);
		write_reg(REG_FB_COEFFS, 64'(FB_RESET));
		write_reg(REG_LOW_GAIN, 64'(GAIN_RESET));

		// Random phases: 1 to 4 register writes (none in the first phase), then a stream of samples
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			if (p > 0) begin
				repeat ($urandom_range(1, 4)) begin
					idx = REG_IDX_W'($urandom_range(0, 7));
					case (idx)
						REG_LOW_GAIN, REG_MID_GAIN, REG_HIGH_GAIN: word = pick_gain_word();
						REG_LOW_COEFFS:  word = pick_coef_word(LOW_COEF_RESET);
						REG_MID_COEFFS:  word = pick_coef_word(MID_COEF_RESET);
						REG_HIGH_COEFFS: word = pick_coef_word(HIGH_COEF_RESET);
						REG_FB_COEFFS:   word = pick_coef_word(64'(FB_RESET));
						default:         word = {$urandom, $urandom};
					endcase
					write_reg(idx, word);
				end
			end
			repeat (PHASE_ITEMS) send_sample(pick_sample());
			wait_idle();
		end

		$display("covered %0d samples and %0d register writes over %0d idle points",
			n_sent, n_writes, n_settings);
		$display("checked %0d output beats, %0d mismatches", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
